FILE: hdl/tpfa_pkg.sv
// Shared types, constants and helpers for the tabulated pair force accumulator.
`timescale 1ns / 1ps
package tpfa_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 65536;

  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_PAIR  = 1'b1;

  localparam logic [47:0] CUTOFF_SQ_RST      = 48'd744163482;
  localparam logic [20:0] TABLE_STEP_RST     = 21'd105;
  localparam logic [31:0] INV_TABLE_STEP_RST = 32'd655360000;
  localparam logic [31:0] TABLE_MAX_R_RST    = 32'd6983516;

  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd30;

  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    REG_CUTOFF_SQ      = 2'd0,
    REG_TABLE_STEP     = 2'd1,
    REG_INV_TABLE_STEP = 2'd2,
    REG_TABLE_MAX_R    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    LK_INTERP = 2'd0,
    LK_FIRST  = 2'd1,
    LK_ZERO   = 2'd2
  } lk_mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQA, S_SQB, S_CHK, S_SQRT, S_LKMUL, S_RDIDX, S_RDNXT,
    S_IP0, S_IP1, S_IP2, S_DIV, S_PX, S_PY, S_ACC, S_FIN
  } state_t;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        table_index;
    logic [31:0]        table_value;
    logic signed [31:0] self_x;
    logic signed [31:0] self_y;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic               last;
  } tpfa_in_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic [15:0]        pairs_used;
  } tpfa_out_t;

  typedef struct packed {
    logic [47:0] cutoff_sq;
    logic [20:0] table_step;
    logic [31:0] inv_table_step;
    logic [31:0] table_max_r;
  } tpfa_cfg_t;

  typedef struct packed {
    logic load;
    logic sq_a;
    logic sq_b;
    logic check;
    logic sqrt_step;
    logic lk_mul;
    logic rd_idx;
    logic rd_nxt;
    logic ip0;
    logic ip1;
    logic ip2;
    logic div_step;
    logic px;
    logic py;
    logic acc;
    logic emit;
  } tpfa_cmd_t;

  typedef struct packed {
    logic in_pair;
    logic last;
    logic use_pair;
  } tpfa_sts_t;

  function automatic logic signed [47:0] sat_acc(input logic signed [47:0] s,
                                                 input logic [31:0] c,
                                                 input logic neg);
    logic signed [49:0] cs;
    logic signed [49:0] t;
    cs = neg ? -$signed({18'b0, c}) : $signed({18'b0, c});
    t  = $signed({{2{s[47]}}, s}) + cs;
    if (t[49:47] != 3'b000 && t[49:47] != 3'b111) begin
      return t[49] ? SUM_MIN : SUM_MAX;
    end
    return t[47:0];
  endfunction

endpackage

FILE: hdl/tpfa_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module tpfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

FILE: hdl/tpfa_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module tpfa_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output tpfa_pkg::tpfa_cfg_t cfg
);
  import tpfa_pkg::*;

  tpfa_cfg_t cfg_r;
  reg_idx_t  sel;
  logic      wr;

  assign sel    = reg_idx_t'(paddr[4:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff_sq      <= CUTOFF_SQ_RST;
      cfg_r.table_step     <= TABLE_STEP_RST;
      cfg_r.inv_table_step <= INV_TABLE_STEP_RST;
      cfg_r.table_max_r    <= TABLE_MAX_R_RST;
    end else if (wr) begin
      case (sel)
        REG_CUTOFF_SQ:      cfg_r.cutoff_sq      <= pwdata[47:0];
        REG_TABLE_STEP:     cfg_r.table_step     <= pwdata[20:0];
        REG_INV_TABLE_STEP: cfg_r.inv_table_step <= pwdata[31:0];
        REG_TABLE_MAX_R:    cfg_r.table_max_r    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_CUTOFF_SQ:      prdata = {16'b0, cfg_r.cutoff_sq};
      REG_TABLE_STEP:     prdata = {43'b0, cfg_r.table_step};
      REG_INV_TABLE_STEP: prdata = {32'b0, cfg_r.inv_table_step};
      REG_TABLE_MAX_R:    prdata = {32'b0, cfg_r.table_max_r};
      default:            prdata = '0;
    endcase
  end
endmodule

FILE: hdl/tpfa_ctrl.sv
// Sequencing state machine for table writes and pair items.
`timescale 1ns / 1ps
module tpfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tpfa_pkg::tpfa_sts_t sts,
  output tpfa_pkg::tpfa_cmd_t cmd
);
  import tpfa_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_pair) state_nxt = S_SQA;
        end
      end
      S_SQA: begin
        cmd.sq_a  = 1'b1;
        state_nxt = S_SQB;
      end
      S_SQB: begin
        cmd.sq_b  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        cnt_nxt   = SQRT_LAST;
        state_nxt = sts.use_pair ? S_SQRT : S_FIN;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r - 5'd1;
        if (cnt_r == '0) state_nxt = S_LKMUL;
      end
      S_LKMUL: begin
        cmd.lk_mul = 1'b1;
        state_nxt  = S_RDIDX;
      end
      S_RDIDX: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_RDNXT;
      end
      S_RDNXT: begin
        cmd.rd_nxt = 1'b1;
        state_nxt  = S_IP0;
      end
      S_IP0: begin
        cmd.ip0   = 1'b1;
        state_nxt = S_IP1;
      end
      S_IP1: begin
        cmd.ip1   = 1'b1;
        state_nxt = S_IP2;
      end
      S_IP2: begin
        cmd.ip2   = 1'b1;
        cnt_nxt   = DIV_LAST;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 5'd1;
        if (cnt_r == '0) state_nxt = S_PX;
      end
      S_PX: begin
        cmd.px    = 1'b1;
        state_nxt = S_PY;
      end
      S_PY: begin
        cmd.py    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (!(out_valid_r && out_stall)) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

FILE: hdl/tpfa_dp.sv
// Datapath: squares, bit-serial square root, table interpolation, dividers, sums.
`timescale 1ns / 1ps
module tpfa_dp #(
  parameter int unsigned TABLE_DEPTH = tpfa_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tpfa_pkg::tpfa_in_t  in_data,
  input  tpfa_pkg::tpfa_cfg_t cfg,
  input  tpfa_pkg::tpfa_cmd_t cmd,
  output tpfa_pkg::tpfa_sts_t sts,
  output tpfa_pkg::tpfa_out_t out_data
);
  import tpfa_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic signed [32:0] dx_w, dy_w;
  logic [32:0]        ax_w, ay_w;
  logic               negx_r, negy_r, last_r;
  logic [32:0]        ax_r, ay_r;
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        prod_r;
  logic [64:0]        a2_r;
  logic [65:0]        s_w, lim_w;
  logic [63:0]        rad_r;
  logic [34:0]        rem_r, remsh_w, trial_w;
  logic [31:0]        root_r;
  logic [27:0]        n_w;
  logic [15:0]        frac_w, frac_r;
  lk_mode_t           mode_w, mode_r;
  logic [AW-1:0]      idx_w, idx_r, rd_addr;
  logic [20:0]        widx_w;
  logic               wr_en;
  logic [31:0]        rd_data, t0_r, t1_r, f_r;
  logic [47:0]        p0_r;
  logic [48:0]        interp_w;
  logic [33:0]        remx_r, remy_r, tx_w, ty_w, r_ext;
  logic [30:0]        dsx_r, dsy_r, ux_r, uy_r;
  logic signed [47:0] sum_x_r, sum_y_r;
  logic [15:0]        pairs_r;
  tpfa_out_t          out_r;

  assign dx_w = $signed({in_data.self_x[31], in_data.self_x})
              - $signed({in_data.other_x[31], in_data.other_x});
  assign dy_w = $signed({in_data.self_y[31], in_data.self_y})
              - $signed({in_data.other_y[31], in_data.other_y});
  assign ax_w = dx_w[32] ? (~dx_w + 33'd1) : dx_w;
  assign ay_w = dy_w[32] ? (~dy_w + 33'd1) : dy_w;

  assign widx_w = {5'b0, in_data.table_index};
  assign wr_en  = cmd.load && (in_data.opcode == OP_TABLE)
                && (widx_w < 21'(TABLE_DEPTH));

  assign s_w   = {1'b0, a2_r} + prod_r;
  assign lim_w = {2'b0, cfg.cutoff_sq, 16'h0};

  assign sts.in_pair  = (in_data.opcode == OP_PAIR);
  assign sts.last     = last_r;
  assign sts.use_pair = (s_w <= lim_w) && (s_w != '0);

  assign remsh_w = {rem_r[32:0], rad_r[63:62]};
  assign trial_w = {1'b0, root_r, 2'b01};

  assign n_w    = prod_r[63:36];
  assign frac_w = prod_r[35:20];
  assign idx_w  = AW'(n_w - 28'd1);

  always_comb begin
    if (root_r < {11'b0, cfg.table_step}) mode_w = LK_FIRST;
    else if (root_r > cfg.table_max_r)    mode_w = LK_ZERO;
    else if (n_w == '0)                   mode_w = LK_FIRST;
    else if (n_w >= 28'(TABLE_DEPTH))     mode_w = LK_ZERO;
    else                                  mode_w = LK_INTERP;
  end

  always_comb begin
    if (cmd.rd_nxt)               rd_addr = idx_r + AW'(1);
    else if (mode_w == LK_INTERP) rd_addr = idx_w;
    else                          rd_addr = '0;
  end

  tpfa_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (widx_w[AW-1:0]),
    .wr_data (in_data.table_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sq_a) begin
      mul_a = ax_r;
      mul_b = ax_r;
    end else if (cmd.sq_b) begin
      mul_a = ay_r;
      mul_b = ay_r;
    end else if (cmd.lk_mul) begin
      mul_a = {1'b0, root_r};
      mul_b = {1'b0, cfg.inv_table_step};
    end else if (cmd.ip0) begin
      mul_a = {1'b0, t0_r};
      mul_b = {16'b0, 17'h10000 - {1'b0, frac_r}};
    end else if (cmd.ip1) begin
      mul_a = {1'b0, t1_r};
      mul_b = {17'b0, frac_r};
    end else if (cmd.px) begin
      mul_a = {1'b0, f_r};
      mul_b = {2'b0, ux_r};
    end else if (cmd.py) begin
      mul_a = {1'b0, f_r};
      mul_b = {2'b0, uy_r};
    end
  end

  assign interp_w = {1'b0, p0_r} + prod_r[48:0];
  assign r_ext    = {2'b0, root_r};
  assign tx_w     = {remx_r[32:0], dsx_r[30]};
  assign ty_w     = {remy_r[32:0], dsy_r[30]};

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.load) begin
      negx_r <= dx_w[32];
      negy_r <= dy_w[32];
      ax_r   <= ax_w;
      ay_r   <= ay_w;
      last_r <= in_data.last;
    end
    if (cmd.sq_b) a2_r <= prod_r[64:0];
    if (cmd.check) begin
      rad_r  <= s_w[63:0];
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (remsh_w >= trial_w) begin
        rem_r  <= remsh_w - trial_w;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= remsh_w;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
    if (cmd.rd_idx) begin
      mode_r <= mode_w;
      frac_r <= frac_w;
      idx_r  <= idx_w;
    end
    if (cmd.rd_nxt) t0_r <= rd_data;
    if (cmd.ip0)    t1_r <= rd_data;
    if (cmd.ip1)    p0_r <= prod_r[47:0];
    if (cmd.ip2) begin
      case (mode_r)
        LK_INTERP: f_r <= interp_w[47:16];
        LK_FIRST:  f_r <= t0_r;
        default:   f_r <= '0;
      endcase
      remx_r <= {2'b0, ax_r[32:1]};
      remy_r <= {2'b0, ay_r[32:1]};
      dsx_r  <= {ax_r[0], 30'b0};
      dsy_r  <= {ay_r[0], 30'b0};
    end
    if (cmd.div_step) begin
      dsx_r <= {dsx_r[29:0], 1'b0};
      dsy_r <= {dsy_r[29:0], 1'b0};
      if (tx_w >= r_ext) begin
        remx_r <= tx_w - r_ext;
        ux_r   <= {ux_r[29:0], 1'b1};
      end else begin
        remx_r <= tx_w;
        ux_r   <= {ux_r[29:0], 1'b0};
      end
      if (ty_w >= r_ext) begin
        remy_r <= ty_w - r_ext;
        uy_r   <= {uy_r[29:0], 1'b1};
      end else begin
        remy_r <= ty_w;
        uy_r   <= {uy_r[29:0], 1'b0};
      end
    end
    if (cmd.emit) out_r <= '{force_x: sum_x_r, force_y: sum_y_r, pairs_used: pairs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      pairs_r <= '0;
    end else if (cmd.emit) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      pairs_r <= '0;
    end else begin
      if (cmd.py) sum_x_r <= sat_acc(sum_x_r, prod_r[61:30], negx_r);
      if (cmd.acc) begin
        sum_y_r <= sat_acc(sum_y_r, prod_r[61:30], negy_r);
        if (pairs_r != 16'hFFFF) pairs_r <= pairs_r + 16'd1;
      end
    end
  end

  assign out_data = out_r;
endmodule

FILE: hdl/tabulated_pair_force_accumulator_core.sv
// Top level of the tabulated pair force accumulator.
`timescale 1ns / 1ps
// A table write (opcode 0) does not hold the input, so the next transfer is taken right after.
// A pair item inside the cutoff holds the input while it runs through these steps in order:
// the two squares and the cutoff check, the one-bit-per-cycle square root, the table
// lookup and interpolation through the single read port of the table RAM, the two
// bit-serial unit-vector dividers, the two projections and sums, and the finish. A pair
// that is not used goes from the cutoff check straight to the finish. A result
// sits in an output register; the block keeps working while it waits and only holds
// when a second result is ready before the first has been taken.
module tabulated_pair_force_accumulator_core #(
  parameter int unsigned TABLE_DEPTH = tpfa_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpfa_pkg::tpfa_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tpfa_pkg::tpfa_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import tpfa_pkg::*;

  tpfa_cfg_t cfg;
  tpfa_cmd_t cmd;
  tpfa_sts_t sts;

  tpfa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpfa_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );
endmodule

FILE: hdl/tpfa_checker.sv
// Port-level assertions for the accumulator core, with the bind that attaches them.
`timescale 1ns / 1ps
module tpfa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input tpfa_pkg::tpfa_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input tpfa_pkg::tpfa_out_t out_data
);
  import tpfa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_pair_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode == OP_PAIR |=> in_stall)
    else $error("pair transfer did not hold input");

  a_table_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode == OP_TABLE |=> !in_stall)
    else $error("table write held input");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without pair work");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind tabulated_pair_force_accumulator_core tpfa_checker u_tpfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: sim/tb_tabulated_pair_force_accumulator_core.sv
// Self-checking testbench for the tabulated pair force accumulator core.
`timescale 1ns / 1ps
module tb_tabulated_pair_force_accumulator_core;
  import tpfa_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 100;
  localparam int HOLD_CYCLES = 2000;
  localparam int PER_PHASE   = 85;

  typedef struct {
    tpfa_in_t  it;
    bit        lit;
    tpfa_out_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  tpfa_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  tpfa_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  logic [31:0] force_mem [65536];
  bit          mem_written [65536];
  longint      acc_fx;
  longint      acc_fy;
  int          acc_pairs;
  logic [47:0] cut_sq;
  logic [20:0] step_q;
  logic [31:0] inv_step;
  logic [31:0] max_r;

  tpfa_out_t   sums_pending [$];
  row_t        dir_rows [$];
  int          errs;
  int          n_sent;
  int          burst_left;
  int          idle_cnt;

  tabulated_pair_force_accumulator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] int_sqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v = val;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic longint sat48(input longint t);
    if (t > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (t < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return t;
  endfunction

  // force magnitude at distance r; returns 0 when an unwritten entry would be read
  function automatic bit force_at(input logic [31:0] r, output logic [31:0] f);
    logic [63:0] q;
    logic [63:0] n;
    logic [63:0] frac;
    logic [63:0] acc;
    int          idx;
    f = '0;
    if (r < step_q) begin
      f = force_mem[0];
      return mem_written[0];
    end
    if (r > max_r) return 1'b1;
    q = 64'(r) * 64'(inv_step);
    n = q >> 36;
    frac = 64'(q[35:20]);
    if (n == 0) begin
      f = force_mem[0];
      return mem_written[0];
    end
    if (n >= 65536) return 1'b1;
    idx = int'(n) - 1;
    acc = 64'(force_mem[idx]) * (64'd65536 - frac) + 64'(force_mem[idx + 1]) * frac;
    f = acc[47:16];
    return mem_written[idx] && mem_written[idx + 1];
  endfunction

  function automatic longint project(input logic [31:0] f, input longint d,
                                     input logic [31:0] r);
    logic [63:0] m;
    logic [63:0] u;
    logic [63:0] c;
    m = (d < 0) ? 64'(-d) : 64'(d);
    u = (m << 30) / 64'(r);
    c = (64'(f) * u) >> 30;
    return (d < 0) ? -longint'(c) : longint'(c);
  endfunction

  function automatic bit pair_eval(input tpfa_in_t it, output bit used,
                                   output longint cx, output longint cy);
    longint      dx;
    longint      dy;
    logic [65:0] ax;
    logic [65:0] ay;
    logic [65:0] s;
    logic [31:0] r;
    logic [31:0] f;
    bit          ok;
    dx = longint'($signed(it.self_x)) - longint'($signed(it.other_x));
    dy = longint'($signed(it.self_y)) - longint'($signed(it.other_y));
    ax = (dx < 0) ? 66'(-dx) : 66'(dx);
    ay = (dy < 0) ? 66'(-dy) : 66'(dy);
    s = ax * ax + ay * ay;
    cx = 0;
    cy = 0;
    used = (s != 0) && (s <= {2'b0, cut_sq, 16'b0});
    if (!used) return 1'b1;
    r = int_sqrt(s[63:0]);
    ok = force_at(r, f);
    cx = project(f, dx, r);
    cy = project(f, dy, r);
    return ok;
  endfunction

  task automatic absorb_item(input tpfa_in_t it, input bit lit, input tpfa_out_t res);
    bit        used;
    bit        ok;
    longint    cx;
    longint    cy;
    tpfa_out_t e;
    if (it.opcode == OP_TABLE) begin
      force_mem[it.table_index] = it.table_value;
      mem_written[it.table_index] = 1'b1;
      return;
    end
    ok = pair_eval(it, used, cx, cy);
    if (used) begin
      acc_fx = sat48(acc_fx + cx);
      acc_fy = sat48(acc_fy + cy);
      if (acc_pairs < 65535) acc_pairs++;
    end
    if (it.last) begin
      e.force_x = acc_fx[47:0];
      e.force_y = acc_fy[47:0];
      e.pairs_used = acc_pairs[15:0];
      sums_pending.insert(sums_pending.size(), lit ? res : e);
      acc_fx = 0;
      acc_fy = 0;
      acc_pairs = 0;
    end
  endtask

  task automatic add_row(input tpfa_in_t it, input bit lit, input tpfa_out_t res);
    row_t rw;
    rw.it = it;
    rw.lit = lit;
    rw.res = res;
    dir_rows.insert(dir_rows.size(), rw);
  endtask

  task automatic send_item(input tpfa_in_t it, input bit lit, input tpfa_out_t res);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    absorb_item(it, lit, res);
    n_sent++;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CUTOFF_SQ:      cut_sq = val[47:0];
      REG_TABLE_STEP:     step_q = val[20:0];
      REG_INV_TABLE_STEP: inv_step = val[31:0];
      REG_TABLE_MAX_R:    max_r = val[31:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input logic [47:0] c, input logic [20:0] s,
                         input logic [31:0] iv, input logic [31:0] m);
    cfg_write(REG_CUTOFF_SQ, 64'(c));
    cfg_write(REG_TABLE_STEP, 64'(s));
    cfg_write(REG_INV_TABLE_STEP, 64'(iv));
    cfg_write(REG_TABLE_MAX_R, 64'(m));
  endtask

  task automatic drain;
    while (sums_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic tpfa_in_t mk_pair(input logic [31:0] sx, input logic [31:0] sy,
                                       input logic [31:0] ox, input logic [31:0] oy,
                                       input logic lst);
    tpfa_in_t it;
    it = '0;
    it.opcode = OP_PAIR;
    it.table_index = 16'($urandom);
    it.table_value = $urandom;
    it.self_x = sx;
    it.self_y = sy;
    it.other_x = ox;
    it.other_y = oy;
    it.last = lst;
    return it;
  endfunction

  function automatic tpfa_in_t mk_tab(input logic [15:0] idx, input logic [31:0] val,
                                      input logic lst);
    tpfa_in_t it;
    it.opcode = OP_TABLE;
    it.table_index = idx;
    it.table_value = val;
    it.self_x = $urandom;
    it.self_y = $urandom;
    it.other_x = $urandom;
    it.other_y = $urandom;
    it.last = lst;
    return it;
  endfunction

  function automatic logic [31:0] offset(input logic [31:0] base);
    logic [31:0] lim;
    logic [31:0] d;
    case ($urandom_range(0, 3))
      0: lim = 32'd8;
      1: lim = (32'(step_q) * 70 > 32'(step_q)) ? 32'(step_q) * 70 : 32'hFFFF_FFFF;
      2: lim = max_r;
      default: return $urandom;
    endcase
    d = $urandom_range(0, lim);
    return $urandom_range(0, 1) ? base + d : base - d;
  endfunction

  function automatic tpfa_in_t rand_item();
    tpfa_in_t    it;
    logic [31:0] ox;
    logic [31:0] oy;
    bit          used;
    longint      cx;
    longint      cy;
    if ($urandom_range(0, 9) == 0) begin
      return mk_tab(($urandom_range(0, 1) ? 16'($urandom_range(0, 70)) : 16'($urandom)),
                    ($urandom_range(0, 7) == 0 ? 32'hFFFF_FFFF : $urandom),
                    1'($urandom));
    end
    repeat (40) begin
      ox = $urandom;
      oy = $urandom;
      if ($urandom_range(0, 19) == 0) it = mk_pair(ox, oy, ox, oy, 1'b0);
      else it = mk_pair(offset(ox), offset(oy), ox, oy, 1'b0);
      it.last = ($urandom_range(0, 3) == 0);
      if (pair_eval(it, used, cx, cy)) return it;
    end
    return mk_pair(ox, oy, ox, oy, 1'($urandom));
  endfunction

  task automatic random_phase(input int cnt);
    tpfa_out_t none;
    none = '0;
    repeat (cnt) send_item(rand_item(), 1'b0, none);
  endtask

  // result checker
  always @(posedge clk) begin
    tpfa_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (sums_pending.size() == 0) begin
        $error("unexpected result transfer %h", out_data);
        errs++;
      end else begin
        e = sums_pending.pop_front();
        if (out_data.force_x !== e.force_x) begin
          $error("force_x expected %h actual %h", e.force_x, out_data.force_x);
          errs++;
        end
        if (out_data.force_y !== e.force_y) begin
          $error("force_y expected %h actual %h", e.force_y, out_data.force_y);
          errs++;
        end
        if (out_data.pairs_used !== e.pairs_used) begin
          $error("pairs_used expected %h actual %h", e.pairs_used, out_data.pairs_used);
          errs++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("tb_tabulated_pair_force_accumulator_core NOT OK");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // receiver stall pattern, with one long hold
  initial begin
    bit held;
    int cyc;
    held = 1'b0;
    cyc = 0;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && n_sent >= 120) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ((cyc / 300) % 3)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= (cyc % 4 == 0);
        endcase
        cyc++;
        @(posedge clk);
      end
    end
  end

  initial begin
    tpfa_out_t zero;
    row_t      rw;
    int        s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errs = 0;
    n_sent = 0;
    burst_left = 0;
    idle_cnt = 0;
    acc_fx = 0;
    acc_fy = 0;
    acc_pairs = 0;
    cut_sq = CUTOFF_SQ_RST;
    step_q = TABLE_STEP_RST;
    inv_step = INV_TABLE_STEP_RST;
    max_r = TABLE_MAX_R_RST;
    zero = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 64; i++) begin
      send_item(mk_tab(16'(i), (i == 2) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h00FF_FFFF),
                       1'b0), 1'b0, zero);
    end

    add_row(mk_pair(0, 0, 0, 0, 1'b1), 1'b1, zero);
    add_row(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 1'b1), 1'b1, zero);
    add_row(mk_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 1'b1), 1'b1, zero);
    add_row(mk_tab(16'd0, 32'hFFFF_FFFF, 1'b1), 1'b0, zero);
    add_row(mk_pair(0, 0, 50, 0, 1'b0), 1'b0, zero);
    add_row(mk_pair(0, 0, 0, -50, 1'b1), 1'b0, zero);
    add_row(mk_tab(16'd1, 32'd0, 1'b0), 1'b0, zero);
    add_row(mk_pair(1000, 0, 0, 0, 1'b1), 1'b0, zero);
    add_row(mk_pair(105, 0, 0, 0, 1'b1), 1'b0, zero);
    add_row(mk_pair(6900000, 0, 0, 0, 1'b1), 1'b0, zero);
    add_row(mk_tab(16'hFFFF, 32'd12345, 1'b1), 1'b0, zero);
    add_row(mk_pair(3000, -2000, -500, 700, 1'b0), 1'b0, zero);
    add_row(mk_pair(-3000, 2000, 500, -700, 1'b1), 1'b0, zero);
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      send_item(rw.it, rw.lit, rw.res);
    end

    random_phase(PER_PHASE);
    in_valid <= 1'b0;
    drain();

    set_cfg(48'hFFFF_FFFF_FFFF, 21'd1, 32'd1, 32'hFFFF_FFFF);
    random_phase(PER_PHASE);
    in_valid <= 1'b0;
    drain();

    set_cfg(48'd0, 21'd1048576, 32'd65536, 32'd0);
    random_phase(PER_PHASE / 2);
    in_valid <= 1'b0;
    drain();

    set_cfg(48'd1 << 26, 21'd4096, 32'd1 << 24, 32'd245760);
    random_phase(PER_PHASE);
    in_valid <= 1'b0;
    drain();

    s = $urandom_range(64, 4096);
    set_cfg(48'(((64'(s) * 60 * 5 / 4) ** 2) >> 16), 21'(s),
            32'((64'd1 << 36) / s + $urandom_range(0, 2)), 32'(s * $urandom_range(10, 80)));
    random_phase(PER_PHASE);
    in_valid <= 1'b0;
    drain();

    if (errs == 0) begin
      $display("tb_tabulated_pair_force_accumulator_core OK");
    end else begin
      $display("tb_tabulated_pair_force_accumulator_core NOT OK");
    end
    $finish;
  end

endmodule
